// ===== hdl/icr_pkg.sv =====
// shared types and constants of the impulse collision resolver
package icr_pkg;

   localparam logic [15:0] SLOP_RESET = 16'd6554;
   localparam logic [15:0] FRAC_RESET = 16'd13107;
   localparam int DIV_STEPS = 32;

   typedef enum logic [0:0] {
      CSR_SLOP = 1'b0,
      CSR_FRAC = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [30:0]        penetration_depth;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_x;
      logic signed [15:0] bounce_target;
      logic signed [15:0] bounce_origin;
      logic [31:0]        weight_target;
      logic [31:0]        weight_origin;
      logic signed [31:0] vel_target_y;
      logic signed [31:0] vel_target_x;
      logic signed [31:0] vel_origin_y;
      logic signed [31:0] vel_origin_x;
   } req_type;

   typedef struct packed {
      logic               both_immovable;
      logic signed [31:0] shift_target_y;
      logic signed [31:0] shift_target_x;
      logic signed [31:0] shift_origin_y;
      logic signed [31:0] shift_origin_x;
      logic signed [31:0] new_vel_target_y;
      logic signed [31:0] new_vel_target_x;
      logic signed [31:0] new_vel_origin_y;
      logic signed [31:0] new_vel_origin_x;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] vox;
      logic signed [31:0] voy;
      logic signed [31:0] vtx;
      logic signed [31:0] vty;
      logic [15:0]        nx_mag;
      logic [15:0]        ny_mag;
      logic               nx_neg;
      logic               ny_neg;
      logic [52:0]        p_mag;
      logic               p_neg;
      logic [46:0]        c_mag;
      logic               imm_o;
      logic               imm_t;
   } carry_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [32:0] sum;
      logic [31:0] h;
      logic [31:0] q;
   } div_type;

endpackage

// ===== hdl/icr_front.sv =====
// front stages: differences, dot product, impulse and correction magnitudes
module icr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  icr_pkg::req_type    in_req,
   input  logic [15:0]         slop,
   input  logic [15:0]         frac,
   output logic                out_valid,
   output icr_pkg::carry_type  out_carry,
   output icr_pkg::div_type    out_div
);

   typedef struct packed {
      logic signed [31:0] vox;
      logic signed [31:0] voy;
      logic signed [31:0] vtx;
      logic signed [31:0] vty;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [15:0]        nx_mag;
      logic [15:0]        ny_mag;
      logic               nx_neg;
      logic               ny_neg;
      logic               imm_o;
      logic               imm_t;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [16:0]        k;
      logic [30:0]        excess;
      logic [31:0]        a;
      logic [32:0]        sum;
      logic signed [48:0] prodx;
      logic signed [48:0] prody;
      logic [46:0]        c_mag;
      logic [35:0]        dot_mag;
      logic               dot_neg;
   } front_type;

   front_type s1_in, s1_ff, s2_in, s2_ff, s3_in, s3_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   icr_pkg::carry_type carry_in, carry_ff;
   icr_pkg::div_type div_in, div_ff;

   logic signed [15:0] emin;
   logic [15:0] e_mag;
   logic [31:0] wa, wb;
   logic signed [49:0] dsum;
   logic [49:0] dmag, drnd;

   always_comb begin
      s1_in = '0;
      s1_in.vox = in_req.vel_origin_x;
      s1_in.voy = in_req.vel_origin_y;
      s1_in.vtx = in_req.vel_target_x;
      s1_in.vty = in_req.vel_target_y;
      s1_in.nx = in_req.normal_x;
      s1_in.ny = in_req.normal_y;
      s1_in.nx_neg = in_req.normal_x[15];
      s1_in.ny_neg = in_req.normal_y[15];
      s1_in.nx_mag = in_req.normal_x[15] ? 16'(-in_req.normal_x) : in_req.normal_x;
      s1_in.ny_mag = in_req.normal_y[15] ? 16'(-in_req.normal_y) : in_req.normal_y;
      s1_in.imm_o = &in_req.weight_origin;
      s1_in.imm_t = &in_req.weight_target;
      s1_in.dvx = $signed({in_req.vel_target_x[31], in_req.vel_target_x})
                - $signed({in_req.vel_origin_x[31], in_req.vel_origin_x});
      s1_in.dvy = $signed({in_req.vel_target_y[31], in_req.vel_target_y})
                - $signed({in_req.vel_origin_y[31], in_req.vel_origin_y});
      emin = (in_req.bounce_origin < in_req.bounce_target) ? in_req.bounce_origin
                                                          : in_req.bounce_target;
      e_mag = emin[15] ? 16'(-emin) : emin;
      s1_in.k = 17'd16384 + {1'b0, e_mag};
      s1_in.excess = (in_req.penetration_depth > {15'd0, slop})
                   ? 31'(in_req.penetration_depth - {15'd0, slop}) : 31'd0;
      wa = (in_req.weight_origin == 32'd0) ? 32'd1 : in_req.weight_origin;
      wb = (in_req.weight_target == 32'd0) ? 32'd1 : in_req.weight_target;
      s1_in.a = wa;
      s1_in.sum = {1'b0, wa} + {1'b0, wb};
   end

   always_comb begin
      s2_in = s1_ff;
      s2_in.prodx = $signed(s1_ff.dvx) * $signed(s1_ff.nx);
      s2_in.prody = $signed(s1_ff.dvy) * $signed(s1_ff.ny);
      s2_in.c_mag = s1_ff.excess * frac;
   end

   always_comb begin
      s3_in = s2_ff;
      dsum = $signed({s2_ff.prodx[48], s2_ff.prodx}) + $signed({s2_ff.prody[48], s2_ff.prody});
      dmag = dsum[49] ? 50'(-dsum) : dsum;
      drnd = dmag + 50'd8192;
      s3_in.dot_mag = drnd[49:14];
      s3_in.dot_neg = dsum[49];
   end

   always_comb begin
      carry_in.vox = s3_ff.vox;
      carry_in.voy = s3_ff.voy;
      carry_in.vtx = s3_ff.vtx;
      carry_in.vty = s3_ff.vty;
      carry_in.nx_mag = s3_ff.nx_mag;
      carry_in.ny_mag = s3_ff.ny_mag;
      carry_in.nx_neg = s3_ff.nx_neg;
      carry_in.ny_neg = s3_ff.ny_neg;
      carry_in.p_mag = s3_ff.k * s3_ff.dot_mag;
      carry_in.p_neg = ~s3_ff.dot_neg;
      carry_in.c_mag = s3_ff.c_mag;
      carry_in.imm_o = s3_ff.imm_o;
      carry_in.imm_t = s3_ff.imm_t;
      div_in.rem = {1'b0, s3_ff.a};
      div_in.sum = s3_ff.sum;
      div_in.h = s3_ff.sum[32:1];
      div_in.q = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         carry_ff <= carry_in;
         div_ff <= div_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_carry = carry_ff;
   assign out_div = div_ff;

endmodule

// ===== hdl/icr_divider.sv =====
// pipelined restoring divider for the target mass share, one quotient bit per stage
module icr_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  icr_pkg::div_type    in_div,
   input  icr_pkg::carry_type  in_carry,
   output logic                out_valid,
   output logic [31:0]         out_q,
   output icr_pkg::carry_type  out_carry
);

   logic               vld_ff [icr_pkg::DIV_STEPS];
   icr_pkg::div_type   div_ff [icr_pkg::DIV_STEPS];
   icr_pkg::carry_type car_ff [icr_pkg::DIV_STEPS];

   genvar i;
   for (i = 0; i < icr_pkg::DIV_STEPS; i++) begin : g_step
      logic               prev_v;
      icr_pkg::div_type   prev_d, nxt_d;
      icr_pkg::carry_type prev_c;
      logic [33:0]        trial;

      if (i == 0) begin : g_first
         assign prev_v = in_valid;
         assign prev_d = in_div;
         assign prev_c = in_carry;
      end else begin : g_next
         assign prev_v = vld_ff[i-1];
         assign prev_d = div_ff[i-1];
         assign prev_c = car_ff[i-1];
      end

      assign trial = {prev_d.rem, prev_d.h[31]};

      always_comb begin
         nxt_d = prev_d;
         nxt_d.h = {prev_d.h[30:0], 1'b0};
         if (trial >= {1'b0, prev_d.sum}) begin
            nxt_d.rem = 33'(trial - {1'b0, prev_d.sum});
            nxt_d.q = {prev_d.q[30:0], 1'b1};
         end else begin
            nxt_d.rem = trial[32:0];
            nxt_d.q = {prev_d.q[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[i] <= nxt_d;
            car_ff[i] <= prev_c;
         end
      end
   end

   assign out_valid = vld_ff[icr_pkg::DIV_STEPS-1];
   assign out_q = div_ff[icr_pkg::DIV_STEPS-1].q;
   assign out_carry = car_ff[icr_pkg::DIV_STEPS-1];

endmodule

// ===== hdl/icr_back.sv =====
// back stages: share products, per-axis deltas, saturation and result register
module icr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         in_q,
   input  icr_pkg::carry_type  in_carry,
   output logic                out_valid,
   output icr_pkg::rsp_type    out_rsp
);

   localparam logic [32:0] SHARE_ONE = 33'h1_0000_0000;

   logic b0_valid_ff, b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   icr_pkg::carry_type c0_ff, c1_ff, c2_ff, c3_ff;
   logic [32:0] st_in, so_in, st_ff, so_ff;
   logic [64:0] plo_t_ff, plo_o_ff, clo_t_ff, clo_o_ff;
   logic [53:0] phi_t_ff, phi_o_ff;
   logic [47:0] chi_t_ff, chi_o_ff;
   logic [54:0] pmid_t, pmid_o;
   logic [48:0] cmid_t, cmid_o;
   logic [46:0] qt_ff, qo_ff;
   logic [43:0] ct_ff, co_ff;
   logic [62:0] qox_ff, qoy_ff, qtx_ff, qty_ff;
   logic [59:0] cox_ff, coy_ff, ctx_ff, cty_ff;
   logic [62:0] qox_r, qoy_r, qtx_r, qty_r;
   logic [59:0] cox_r, coy_r, ctx_r, cty_r;
   logic [54:0] pr_t, pr_o;
   logic [48:0] cr_t, cr_o;
   icr_pkg::rsp_type rsp_in, rsp_ff;

   function automatic logic signed [31:0] acc_sat(input logic signed [31:0] base,
                                                  input logic [38:0] mag, input logic sub);
      logic signed [41:0] sum;
      logic signed [31:0] res;
      sum = sub ? (42'(base) - $signed({3'b000, mag})) : (42'(base) + $signed({3'b000, mag}));
      if (sum[41] && !(&sum[40:31])) begin
         res = 32'sh8000_0000;
      end else if (!sum[41] && (|sum[40:31])) begin
         res = 32'sh7FFF_FFFF;
      end else begin
         res = sum[31:0];
      end
      return res;
   endfunction

   always_comb begin
      if (in_carry.imm_o) begin
         st_in = SHARE_ONE;
      end else if (in_carry.imm_t) begin
         st_in = '0;
      end else begin
         st_in = {1'b0, in_q};
      end
      so_in = SHARE_ONE - st_in;
   end

   always_comb begin
      pmid_t = 55'(phi_t_ff) + 55'(plo_t_ff[64:32]);
      pmid_o = 55'(phi_o_ff) + 55'(plo_o_ff[64:32]);
      cmid_t = 49'(chi_t_ff) + 49'(clo_t_ff[64:32]);
      cmid_o = 49'(chi_o_ff) + 49'(clo_o_ff[64:32]);
      pr_t = pmid_t + 55'd8;
      pr_o = pmid_o + 55'd8;
      cr_t = cmid_t + 49'd8;
      cr_o = cmid_o + 49'd8;
   end

   always_comb begin
      qox_r = qox_ff + 63'h80_0000;
      qoy_r = qoy_ff + 63'h80_0000;
      qtx_r = qtx_ff + 63'h80_0000;
      qty_r = qty_ff + 63'h80_0000;
      cox_r = cox_ff + 60'h200_0000;
      coy_r = coy_ff + 60'h200_0000;
      ctx_r = ctx_ff + 60'h200_0000;
      cty_r = cty_ff + 60'h200_0000;
      rsp_in = '0;
      if (c3_ff.imm_o && c3_ff.imm_t) begin
         rsp_in.both_immovable = 1'b1;
      end else begin
         rsp_in.new_vel_origin_x = acc_sat(c3_ff.vox, qox_r[62:24], ~(c3_ff.p_neg ^ c3_ff.nx_neg));
         rsp_in.new_vel_origin_y = acc_sat(c3_ff.voy, qoy_r[62:24], ~(c3_ff.p_neg ^ c3_ff.ny_neg));
         rsp_in.new_vel_target_x = acc_sat(c3_ff.vtx, qtx_r[62:24], c3_ff.p_neg ^ c3_ff.nx_neg);
         rsp_in.new_vel_target_y = acc_sat(c3_ff.vty, qty_r[62:24], c3_ff.p_neg ^ c3_ff.ny_neg);
         rsp_in.shift_origin_x = acc_sat('0, {5'd0, cox_r[59:26]}, ~c3_ff.nx_neg);
         rsp_in.shift_origin_y = acc_sat('0, {5'd0, coy_r[59:26]}, ~c3_ff.ny_neg);
         rsp_in.shift_target_x = acc_sat('0, {5'd0, ctx_r[59:26]}, c3_ff.nx_neg);
         rsp_in.shift_target_y = acc_sat('0, {5'd0, cty_r[59:26]}, c3_ff.ny_neg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else if (en) begin
         b0_valid_ff <= in_valid;
         b1_valid_ff <= b0_valid_ff;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff <= in_carry;
         st_ff <= st_in;
         so_ff <= so_in;
         c1_ff <= c0_ff;
         plo_t_ff <= c0_ff.p_mag[31:0] * st_ff;
         plo_o_ff <= c0_ff.p_mag[31:0] * so_ff;
         phi_t_ff <= c0_ff.p_mag[52:32] * st_ff;
         phi_o_ff <= c0_ff.p_mag[52:32] * so_ff;
         clo_t_ff <= c0_ff.c_mag[31:0] * st_ff;
         clo_o_ff <= c0_ff.c_mag[31:0] * so_ff;
         chi_t_ff <= c0_ff.c_mag[46:32] * st_ff;
         chi_o_ff <= c0_ff.c_mag[46:32] * so_ff;
         c2_ff <= c1_ff;
         qt_ff <= pr_t[50:4];
         qo_ff <= pr_o[50:4];
         ct_ff <= cr_t[47:4];
         co_ff <= cr_o[47:4];
         c3_ff <= c2_ff;
         qox_ff <= qo_ff * c2_ff.nx_mag;
         qoy_ff <= qo_ff * c2_ff.ny_mag;
         qtx_ff <= qt_ff * c2_ff.nx_mag;
         qty_ff <= qt_ff * c2_ff.ny_mag;
         cox_ff <= co_ff * c2_ff.nx_mag;
         coy_ff <= co_ff * c2_ff.ny_mag;
         ctx_ff <= ct_ff * c2_ff.nx_mag;
         cty_ff <= ct_ff * c2_ff.ny_mag;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = b4_valid_ff;
   assign out_rsp = rsp_ff;

endmodule

// ===== hdl/impulse_collision_resolver_unit.sv =====
// top level of the impulse collision resolver: ports, control registers, stall control
//
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  req_tdata: one contact
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser: one result
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// one item per cycle sustained while results are taken
// the pipeline is the 32-stage share divider plus 4 front and 5 back stages
// synchronous reset clears valid bits and restores the register defaults
// a stalled result holds the whole pipeline; bubbles are not squeezed out
module impulse_collision_resolver_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vel_origin_x, vel_origin_y, vel_target_x, vel_target_y, weight_origin,
   // weight_target, bounce_origin, bounce_target, normal_x, normal_y,
   // penetration_depth, zero pad
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_vel_origin_x, new_vel_origin_y, new_vel_target_x, new_vel_target_y,
   // shift_origin_x, shift_origin_y, shift_target_x, shift_target_y
   output logic [255:0] rsp_tdata,
   // both_immovable
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);

   logic [15:0] slop_ff, frac_ff;
   logic en;
   icr_pkg::req_type req;
   logic front_valid, div_valid, back_valid;
   icr_pkg::carry_type front_carry, div_carry;
   icr_pkg::div_type front_div;
   logic [31:0] div_q;
   icr_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;
   assign en = ~back_valid | rsp_tready;
   assign req_tready = en;
   assign req = req_tdata[286:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff <= icr_pkg::SLOP_RESET;
         frac_ff <= icr_pkg::FRAC_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            icr_pkg::CSR_SLOP: slop_ff <= csr_data;
            icr_pkg::CSR_FRAC: frac_ff <= csr_data;
            default: ;
         endcase
      end
   end

   icr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_req    (req),
      .slop      (slop_ff),
      .frac      (frac_ff),
      .out_valid (front_valid),
      .out_carry (front_carry),
      .out_div   (front_div)
   );

   icr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_div    (front_div),
      .in_carry  (front_carry),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_carry (div_carry)
   );

   icr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_q      (div_q),
      .in_carry  (div_carry),
      .out_valid (back_valid),
      .out_rsp   (rsp)
   );

   assign rsp_tvalid = back_valid;
   assign rsp_tdata = rsp[255:0];
   assign rsp_tuser = rsp.both_immovable;

endmodule

// ===== test/tb_impulse_collision_resolver_unit.sv =====
// testbench for the impulse collision resolver: random and directed contacts checked against a predictor
`timescale 1ns / 1ps

module tb_impulse_collision_resolver_unit;
   import icr_pkg::*;

   typedef enum logic [1:0] {
      JOB_CONTACT,
      JOB_SETTING,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type  kind;
      req_type       contact;
      csr_index_type index;
      logic [15:0]   value;
   } job_type;

   localparam logic [31:0] IMMOVABLE = 32'hFFFF_FFFF;
   localparam int LATENCY = 41;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   job_type     pending_jobs[$];
   rsp_type     expected_results[$];
   logic [15:0] slop_setting = SLOP_RESET;
   logic [15:0] fraction_setting = FRAC_RESET;
   int          failures = 0;
   int          contacts_taken = 0;
   int          cycle_count = 0;
   bit          req_fire = 1'b0;
   bit          csr_fire = 1'b0;
   bit          calm = 1'b0;

   impulse_collision_resolver_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // round to nearest, halves away from zero
   function automatic longint round_shift(longint x, int s);
      longint unsigned m;
      m = (x < 0) ? longint'(-x) : x;
      m = (m + (64'd1 << (s - 1))) >> s;
      if (x < 0) return -longint'(m);
      return longint'(m);
   endfunction

   function automatic longint scale_by_share(longint a, longint unsigned share, int s);
      longint unsigned m, mid, r;
      m = (a < 0) ? longint'(-a) : a;
      mid = (m >> 32) * share + (((m & 64'hFFFF_FFFF) * share) >> 32);
      r = (mid + (64'd1 << (s - 33))) >> (s - 32);
      if (a < 0) return -longint'(r);
      return longint'(r);
   endfunction

   function automatic logic [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
   endfunction

   function automatic rsp_type resolve_contact(req_type c, logic [15:0] slop,
                                               logic [15:0] fraction);
      rsp_type r;
      longint vox, voy, vtx, vty, nx, ny, bo, bt, e, k, dot, p, qt, qo;
      longint excess, corr, ct, co;
      longint unsigned wo, wt, sum, st, so;
      vox = c.vel_origin_x;
      voy = c.vel_origin_y;
      vtx = c.vel_target_x;
      vty = c.vel_target_y;
      nx = c.normal_x;
      ny = c.normal_y;
      bo = c.bounce_origin;
      bt = c.bounce_target;
      wo = c.weight_origin;
      wt = c.weight_target;
      r = '0;
      if (c.weight_origin == IMMOVABLE && c.weight_target == IMMOVABLE) begin
         r.both_immovable = 1'b1;
         return r;
      end
      if (c.weight_origin == IMMOVABLE) begin
         st = 64'd1 << 32;
      end else if (c.weight_target == IMMOVABLE) begin
         st = 0;
      end else begin
         if (wo == 0) wo = 1;
         if (wt == 0) wt = 1;
         sum = wo + wt;
         st = ((wo << 32) + (sum >> 1)) / sum;
      end
      so = (64'd1 << 32) - st;
      e = (bo < bt) ? bo : bt;
      k = 16384 + ((e < 0) ? -e : e);
      dot = round_shift((vtx - vox) * nx + (vty - voy) * ny, 14);
      p = -(k * dot);
      qt = scale_by_share(p, st, 36);
      qo = scale_by_share(p, so, 36);
      r.new_vel_origin_x = clamp32(vox - round_shift(qo * nx, 24));
      r.new_vel_origin_y = clamp32(voy - round_shift(qo * ny, 24));
      r.new_vel_target_x = clamp32(vtx + round_shift(qt * nx, 24));
      r.new_vel_target_y = clamp32(vty + round_shift(qt * ny, 24));
      excess = longint'(c.penetration_depth) - longint'(slop);
      if (excess < 0) excess = 0;
      corr = excess * longint'(fraction);
      ct = scale_by_share(corr, st, 36);
      co = scale_by_share(corr, so, 36);
      r.shift_origin_x = clamp32(-round_shift(co * nx, 26));
      r.shift_origin_y = clamp32(-round_shift(co * ny, 26));
      r.shift_target_x = clamp32(round_shift(ct * nx, 26));
      r.shift_target_y = clamp32(round_shift(ct * ny, 26));
      return r;
   endfunction

   function automatic req_type random_contact();
      req_type c;
      int pick;
      c.vel_origin_x = $urandom;
      c.vel_origin_y = $urandom;
      c.vel_target_x = $urandom;
      c.vel_target_y = $urandom;
      if ($urandom_range(0, 2) != 0) begin
         c.vel_origin_x = $signed(c.vel_origin_x) >>> $urandom_range(4, 14);
         c.vel_origin_y = $signed(c.vel_origin_y) >>> $urandom_range(4, 14);
         c.vel_target_x = $signed(c.vel_target_x) >>> $urandom_range(4, 14);
         c.vel_target_y = $signed(c.vel_target_y) >>> $urandom_range(4, 14);
      end
      c.weight_origin = $urandom >> $urandom_range(0, 24);
      c.weight_target = $urandom >> $urandom_range(0, 24);
      pick = $urandom_range(0, 19);
      if (pick == 0) c.weight_origin = IMMOVABLE;
      if (pick == 1) c.weight_target = IMMOVABLE;
      if (pick == 2) c.weight_origin = 0;
      if (pick == 3) begin
         c.weight_origin = IMMOVABLE;
         c.weight_target = IMMOVABLE;
      end
      c.bounce_origin = $urandom;
      c.bounce_target = $urandom;
      if ($urandom_range(0, 1) != 0) begin
         c.bounce_origin = $urandom_range(0, 16384);
         c.bounce_target = $urandom_range(0, 16384);
      end
      if ($urandom_range(0, 9) == 0) begin
         c.normal_x = $urandom;
         c.normal_y = $urandom;
      end else begin
         c.normal_x = $urandom_range(0, 32768) - 16384;
         c.normal_y = $urandom_range(0, 32768) - 16384;
      end
      c.penetration_depth = $urandom;
      if ($urandom_range(0, 2) != 0) c.penetration_depth = $urandom_range(0, 200000);
      return c;
   endfunction

   function automatic req_type plain_contact();
      req_type c;
      c = '0;
      c.vel_origin_x = 32'sd65536;
      c.vel_target_x = -32'sd65536;
      c.weight_origin = 32'd65536;
      c.weight_target = 32'd131072;
      c.bounce_origin = 16'sd8192;
      c.bounce_target = 16'sd12000;
      c.normal_x = 16'sd16384;
      c.penetration_depth = 31'd40000;
      return c;
   endfunction

   task automatic add_contact(req_type c);
      job_type j;
      j.kind = JOB_CONTACT;
      j.contact = c;
      j.index = CSR_SLOP;
      j.value = '0;
      pending_jobs.push_back(j);
   endtask

   task automatic add_setting(csr_index_type index, logic [15:0] value);
      job_type j;
      j.kind = JOB_SETTING;
      j.contact = '0;
      j.index = index;
      j.value = value;
      pending_jobs.push_back(j);
   endtask

   task automatic add_drain();
      job_type j;
      j.kind = JOB_DRAIN;
      j.contact = '0;
      j.index = CSR_SLOP;
      j.value = '0;
      pending_jobs.push_back(j);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   // sender
   int send_gap = 0;
   always @(negedge clock) begin
      logic next_valid, next_csr_valid, busy;
      job_type j;
      next_valid = req_tvalid;
      next_csr_valid = csr_valid;
      if (!reset) begin
         if (req_fire) next_valid = 1'b0;
         if (csr_fire) next_csr_valid = 1'b0;
         busy = next_valid || next_csr_valid;
         if (!busy && send_gap > 0) begin
            send_gap--;
         end else if (!busy && pending_jobs.size() > 0) begin
            j = pending_jobs[0];
            case (j.kind)
               JOB_CONTACT: begin
                  req_tdata <= {1'b0, j.contact};
                  next_valid = 1'b1;
                  void'(pending_jobs.pop_front());
                  if (!calm && cycle_count[8] && $urandom_range(0, 7) == 0)
                     send_gap = $urandom_range(1, 18);
               end
               JOB_SETTING: begin
                  if (expected_results.size() == 0 && !rsp_tvalid) begin
                     csr_index <= j.index;
                     csr_data <= j.value;
                     next_csr_valid = 1'b1;
                     void'(pending_jobs.pop_front());
                  end
               end
               default: begin
                  if (expected_results.size() == 0) void'(pending_jobs.pop_front());
               end
            endcase
         end
         if (pending_jobs.size() < 150) calm = 1'b1;
      end
      req_tvalid <= next_valid;
      csr_valid <= next_csr_valid;
   end

   // receiver
   int stall_left = 0;
   bit long_hold_done = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && contacts_taken >= 300) begin
            long_hold_done = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && cycle_count[9] && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, want;
      cycle_count++;
      req_fire = 1'b0;
      csr_fire = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_fire = 1'b1;
            if (csr_index_type'(csr_index) == CSR_SLOP) slop_setting = csr_data;
            else fraction_setting = csr_data;
         end
         if (req_tvalid && req_tready) begin
            req_fire = 1'b1;
            contacts_taken++;
            expected_results.push_back(
               resolve_contact(req_type'(req_tdata[286:0]), slop_setting, fraction_setting));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_results.size() == 0) begin
               $error("result with no item outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("new_vel_origin_x", want.new_vel_origin_x, got.new_vel_origin_x);
               check_field("new_vel_origin_y", want.new_vel_origin_y, got.new_vel_origin_y);
               check_field("new_vel_target_x", want.new_vel_target_x, got.new_vel_target_x);
               check_field("new_vel_target_y", want.new_vel_target_y, got.new_vel_target_y);
               check_field("shift_origin_x", want.shift_origin_x, got.shift_origin_x);
               check_field("shift_origin_y", want.shift_origin_y, got.shift_origin_y);
               check_field("shift_target_x", want.shift_target_x, got.shift_target_x);
               check_field("shift_target_y", want.shift_target_y, got.shift_target_y);
               check_field("both_immovable", 32'(want.both_immovable),
                           32'(got.both_immovable));
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      req_type c;
      logic [15:0] slops[4], fractions[4];
      slops = '{16'd0, 16'd65535, 16'd100, 16'd6554};
      fractions = '{16'd65535, 16'd0, 16'd30000, 16'd13107};

      // directed contacts under reset settings
      add_contact(plain_contact());
      c = plain_contact(); c.weight_origin = IMMOVABLE; add_contact(c);
      c = plain_contact(); c.weight_target = IMMOVABLE; add_contact(c);
      c.weight_origin = IMMOVABLE; add_contact(c);
      c = plain_contact(); c.weight_origin = 0; c.weight_target = 0; add_contact(c);
      c = plain_contact(); c.weight_origin = 1; c.weight_target = 32'hFFFF_FFFE; add_contact(c);
      c = plain_contact(); c.normal_x = 16'sh7FFF; c.normal_y = 16'sh8000; add_contact(c);
      c = plain_contact(); c.normal_x = -16'sd16384; c.normal_y = 16'sd16384; add_contact(c);
      c = plain_contact(); c.penetration_depth = 31'd100; add_contact(c);
      c = plain_contact(); c.penetration_depth = 31'h7FFF_FFFF; add_contact(c);
      c = plain_contact(); c.penetration_depth = 0; add_contact(c);
      c = plain_contact();
      c.vel_origin_x = 32'sh7FFF_FFFF; c.vel_origin_y = 32'sh7FFF_FFFF;
      c.vel_target_x = 32'sh8000_0000; c.vel_target_y = 32'sh8000_0000;
      c.normal_x = 16'sh7FFF; c.normal_y = 16'sh7FFF;
      c.bounce_origin = 16'sh8000; c.bounce_target = 16'sh7FFF;
      add_contact(c);
      c.vel_origin_x = 32'sh8000_0000; c.vel_target_x = 32'sh7FFF_FFFF;
      c.normal_x = 16'sh8000; c.normal_y = 0;
      add_contact(c);
      c = plain_contact(); c.bounce_origin = -16'sd20000; c.bounce_target = 16'sd30000;
      add_contact(c);
      c = plain_contact(); c.bounce_origin = 0; c.bounce_target = 0; c.normal_x = 0;
      add_contact(c);
      c = '1; c.normal_x = 16'sd5000; c.weight_origin = 32'd3; add_contact(c);

      for (int phase = 0; phase < 4; phase++) begin
         add_setting(CSR_SLOP, slops[phase]);
         add_setting(CSR_FRAC, fractions[phase]);
         for (int n = 0; n < 420; n++) begin
            if (phase == 1 && n == 200) add_drain();
            add_contact(random_contact());
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      forever begin
         @(posedge clock);
         if (pending_jobs.size() == 0 && !req_tvalid && !csr_valid
             && expected_results.size() == 0)
            break;
      end
      repeat (LATENCY + 20) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
